// ----- design/tdi_pkg.sv -----
package tdi_pkg;

  localparam int DEF_RING_DEPTH = 64;
  localparam int CH       = 4;
  localparam int SAMPLE_W = 16;
  localparam int TIME_W   = 32;
  localparam int DELAY_W  = 20;
  localparam int TD_W     = TIME_W + 1;   // now - delay
  localparam int DIFF_W   = TIME_W + 2;   // entry time - delayed time
  localparam int PROD_W   = DIFF_W + SAMPLE_W;
  localparam int NUM_W    = PROD_W + 1;
  localparam int DEN_W    = TIME_W + 1;
  localparam int ROW_W    = TIME_W + CH * SAMPLE_W;
  localparam int CH_W     = (CH > 1) ? $clog2(CH) : 1;

  localparam int OP_STORE = 0;
  localparam int OP_READ  = 1;

  localparam int REG_DELAY = 0;
  localparam int REG_INIT  = 1;

  localparam logic [DELAY_W-1:0]  DELAY_RST = DELAY_W'(100);
  localparam logic [SAMPLE_W-1:0] INIT_RST  = '0;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
  } div_req_t;

endpackage

// ----- design/tdi_ring.sv -----
module tdi_ring #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 96
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/tdi_div.sv -----
module tdi_div (
  input  logic                       clk,
  input  logic                       rst,
  input  tdi_pkg::div_req_t          req,
  output logic                       done,
  output logic signed [tdi_pkg::SAMPLE_W-1:0] quot
);
  import tdi_pkg::*;

  localparam int NN_W = NUM_W + 2;
  localparam int Q_W  = SAMPLE_W + 1;

  logic [NUM_W-1:0] n_abs;
  logic [DEN_W-1:0] d_abs;
  logic [NN_W-1:0]  nn;
  logic [NN_W-1:0]  d2;
  logic             over;

  logic             busy;
  logic             neg;
  logic [NN_W-1:0]  rem;
  logic [NN_W-1:0]  dsh;
  logic [Q_W-1:0]   q;
  logic [4:0]       cnt;

  // rounded quotient is floor((2n + d) / 2d)
  always_comb begin
    n_abs = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
    d_abs = req.den[DEN_W-1] ? DEN_W'(-req.den) : DEN_W'(req.den);
    nn    = {n_abs, 1'b0} + NN_W'(d_abs);
    d2    = NN_W'({d_abs, 1'b0});
    over  = nn >= (d2 << Q_W);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        neg <= req.num[NUM_W-1] ^ req.den[DEN_W-1];
        rem <= nn;
        dsh <= d2 << (Q_W - 1);
        cnt <= 5'(Q_W - 1);
        if (over) begin
          q    <= '1;
          done <= 1'b1;
        end else begin
          q    <= '0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          q   <= {q[Q_W-2:0], 1'b1};
        end else begin
          q   <= {q[Q_W-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // saturate to the sample range
  always_comb begin
    if (neg) begin
      if (q > Q_W'(32768)) quot = 16'sh8000;
      else                 quot = SAMPLE_W'(-q);
    end else begin
      if (q > Q_W'(32767)) quot = 16'sh7fff;
      else                 quot = q[SAMPLE_W-1:0];
    end
  end

endmodule

// ----- design/timestamped_delay_interpolator_unit.sv -----
// Channel  Ports           Payload
// in       s_axis_*        tuser: opcode; tdata: now_time, sample_0..3
// out      m_axis_*        tuser: underrun; tdata: delayed_0..3
// config   APB (psel ...)  0x0 delay_ticks, 0x4 initial_value
//
// Store: two ring reads, one write and the output load lie between accept and
// the next ready.
// Read: a binary search (at most log2 RING_DEPTH steps) and a closing check,
// the bracket reads, then per channel the multiply states M1 to M3 and the
// divider (cut short when the quotient saturates, skipped for equal bracket
// times), then the output load.
// Reset and every register write refill the ring with s_axis_tready low.
// A stalled result holds in the output register.
module timestamped_delay_interpolator_unit #(
  parameter int RING_DEPTH = tdi_pkg::DEF_RING_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // now_time, sample_0, sample_1, sample_2, sample_3
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // delayed_0, delayed_1, delayed_2, delayed_3
  output logic        m_axis_tuser,   // underrun
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tdi_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int TA_W = 48;

  localparam logic [4:0] S_FILL0 = 5'd0,  S_FILL1 = 5'd1,  S_FILL2 = 5'd2,
                         S_IDLE  = 5'd3,  S_ST0   = 5'd4,  S_ST1   = 5'd5,
                         S_ST2   = 5'd6,  S_RS    = 5'd7,  S_RC    = 5'd8,
                         S_RA    = 5'd9,  S_RB    = 5'd10, S_RD    = 5'd11,
                         S_M1    = 5'd12, S_M2    = 5'd13, S_M3    = 5'd14,
                         S_DW    = 5'd15, S_FIN   = 5'd16;

  logic [4:0] state;

  logic [DELAY_W-1:0]  delay_ticks;
  logic [SAMPLE_W-1:0] initial_value;

  logic signed [TIME_W-1:0]   now_t;
  logic [CH*SAMPLE_W-1:0]     samples;
  logic signed [TD_W-1:0]     td;
  logic                       underrun;

  logic [AW-1:0] wp;
  logic [AW-1:0] lo, hi, mid, fidx;
  logic [CH_W-1:0] ch;
  logic signed [TA_W-1:0] tacc;

  logic signed [TIME_W-1:0]   ta, tb;
  logic [CH*SAMPLE_W-1:0]     va, vb;
  logic [CH*SAMPLE_W-1:0]     res;

  logic signed [DIFF_W-1:0]   mul_a;
  logic signed [SAMPLE_W-1:0] mul_b;
  logic signed [PROD_W-1:0]   prod, acc;
  logic signed [DEN_W-1:0]    del;
  logic signed [NUM_W-1:0]    num;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [ROW_W-1:0] wdata, rdata;
  logic signed [TIME_W-1:0] rtime;

  div_req_t dreq;
  logic     ddone;
  logic signed [SAMPLE_W-1:0] dquot;

  logic [AW:0] mid_sum;
  logic [AW-1:0] newest;
  logic signed [TIME_W-1:0] tsat;
  logic cfg_we;

  function automatic logic [AW-1:0] wrap(input logic [AW:0] x);
    logic [AW:0] d;
    d = (AW+1)'(RING_DEPTH);
    return (x >= d) ? AW'(x - d) : x[AW-1:0];
  endfunction

  tdi_ring #(.DEPTH(RING_DEPTH), .WIDTH(ROW_W)) u_ring (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  tdi_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .quot(dquot));

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign s_axis_tready = (state == S_IDLE);
  assign rtime = rdata[TIME_W-1:0];
  assign del = DEN_W'(tb) - DEN_W'(ta);
  assign num = NUM_W'(acc) + NUM_W'(prod);
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign newest = wrap({1'b0, wp} + (AW+1)'(RING_DEPTH - 1));

  always_comb begin
    unique case (paddr[2])
      1'b0:    prdata = 32'(delay_ticks);
      default: prdata = {{16{initial_value[SAMPLE_W-1]}}, initial_value};
    endcase
  end

  always_comb begin
    if (tacc > TA_W'(64'sh7fffffff))        tsat = 32'sh7fffffff;
    else if (tacc < -TA_W'(64'sh80000000))  tsat = 32'sh80000000;
    else                                    tsat = tacc[TIME_W-1:0];
  end

  // shared multiplier operands
  always_comb begin
    unique case (state)
      S_M1: begin
        mul_a = DIFF_W'(tb) - DIFF_W'(td);
        mul_b = va[ch*SAMPLE_W +: SAMPLE_W];
      end
      S_M2: begin
        mul_a = DIFF_W'(td) - DIFF_W'(ta);
        mul_b = vb[ch*SAMPLE_W +: SAMPLE_W];
      end
      default: begin
        mul_a = DIFF_W'({1'b0, delay_ticks});
        mul_b = SAMPLE_W'(RING_DEPTH - 1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_comb begin
    raddr = wp;
    unique case (state)
      S_ST1:   raddr = newest;
      S_RS:    raddr = wrap({1'b0, mid_sum[AW:1]} + {1'b0, wp});
      S_RA:    raddr = wrap({1'b0, lo} + {1'b0, wp});
      S_RB:    raddr = wrap({1'b0, hi} + {1'b0, wp});
      default: raddr = wp;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = fidx;
    wdata = {{CH{initial_value}}, tsat};
    if (state == S_FILL2) begin
      we = 1'b1;
    end else if (state == S_ST2) begin
      we    = 1'b1;
      waddr = (now_t > rtime) ? wp : newest;
      wdata = {samples, now_t};
    end
  end

  always_comb begin
    dreq.start = (state == S_M3) && (del != '0);
    dreq.num   = num;
    dreq.den   = del;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_FILL0;
      delay_ticks   <= DELAY_RST;
      initial_value <= INIT_RST;
      m_axis_tvalid <= 1'b0;
      wp            <= '0;
    end else begin
      // drop the taken item unless a new one loads in its place
      if (m_axis_tvalid && m_axis_tready && (cfg_we || state != S_FIN)) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (32'(paddr[2]))
          REG_DELAY: delay_ticks   <= pwdata[DELAY_W-1:0];
          REG_INIT:  initial_value <= pwdata[SAMPLE_W-1:0];
          default:   delay_ticks   <= delay_ticks;
        endcase
        state <= S_FILL0;
      end else begin
        unique case (state)
          S_FILL0: begin
            wp    <= '0;
            fidx  <= '0;
            state <= S_FILL1;
          end
          S_FILL1: begin
            tacc  <= -TA_W'(prod) - TA_W'(1);
            state <= S_FILL2;
          end
          S_FILL2: begin
            tacc <= tacc + TA_W'($signed({1'b0, delay_ticks})) - TA_W'(1);
            fidx <= fidx + AW'(1);
            if (fidx == AW'(RING_DEPTH - 1)) state <= S_IDLE;
          end
          S_IDLE: begin
            if (s_axis_tvalid) begin
              now_t    <= s_axis_tdata[TIME_W-1:0];
              samples  <= s_axis_tdata[TIME_W +: CH*SAMPLE_W];
              td       <= TD_W'($signed(s_axis_tdata[TIME_W-1:0]))
                          - TD_W'({1'b0, delay_ticks});
              underrun <= 1'b0;
              lo       <= '0;
              hi       <= AW'(RING_DEPTH - 1);
              ch       <= '0;
              state    <= (s_axis_tuser == 1'(OP_READ)) ? S_RS : S_ST0;
            end
          end
          S_ST0: state <= S_ST1;
          S_ST1: begin
            underrun <= td < TD_W'(rtime);
            state    <= S_ST2;
          end
          S_ST2: begin
            // append when later than the newest entry
            if (now_t > rtime) wp <= wrap({1'b0, wp} + (AW+1)'(1));
            res   <= '0;
            state <= S_FIN;
          end
          S_RS: begin
            mid <= mid_sum[AW:1];
            if ({1'b0, hi} > {1'b0, lo} + (AW+1)'(1)) state <= S_RC;
            else                                      state <= S_RA;
          end
          S_RC: begin
            if (td < TD_W'(rtime))      hi <= mid;
            else if (td > TD_W'(rtime)) lo <= mid;
            else begin
              lo <= mid;
              hi <= mid;
            end
            state <= S_RS;
          end
          S_RA: state <= S_RB;
          S_RB: begin
            ta    <= rtime;
            va    <= rdata[TIME_W +: CH*SAMPLE_W];
            state <= S_RD;
          end
          S_RD: begin
            tb    <= rtime;
            vb    <= rdata[TIME_W +: CH*SAMPLE_W];
            state <= S_M1;
          end
          S_M1: state <= S_M2;
          S_M2: begin
            acc   <= prod;
            state <= S_M3;
          end
          S_M3: begin
            if (del == '0) begin
              // equal bracket times: hold the lower entry
              res[ch*SAMPLE_W +: SAMPLE_W] <= va[ch*SAMPLE_W +: SAMPLE_W];
              ch    <= ch + CH_W'(1);
              state <= (ch == CH_W'(CH - 1)) ? S_FIN : S_M1;
            end else begin
              state <= S_DW;
            end
          end
          S_DW: begin
            if (ddone) begin
              res[ch*SAMPLE_W +: SAMPLE_W] <= dquot;
              ch    <= ch + CH_W'(1);
              state <= (ch == CH_W'(CH - 1)) ? S_FIN : S_M1;
            end
          end
          S_FIN: begin
            if (!m_axis_tvalid || m_axis_tready) begin
              m_axis_tvalid <= 1'b1;
              m_axis_tdata  <= res;
              m_axis_tuser  <= underrun;
              state         <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

endmodule

// ----- bench/timestamped_delay_interpolator_unit_test.sv -----
module timestamped_delay_interpolator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tdi_pkg::*;

  localparam int DEPTH = DEF_RING_DEPTH;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 200;

  typedef struct packed {
    logic        underrun;
    logic [63:0] delayed;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;   // now_time, sample_0, sample_1, sample_2, sample_3
  logic        s_axis_tuser = 1'b0; // opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // delayed_0, delayed_1, delayed_2, delayed_3
  logic        m_axis_tuser;        // underrun
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  timestamped_delay_interpolator_unit dut (.*);

  // predictor state
  logic [DELAY_W-1:0]         delay_reg;
  logic signed [SAMPLE_W-1:0] fill_value;
  logic signed [31:0]         ring_time [DEPTH];
  logic signed [15:0]         ring_val [CH][DEPTH];
  int                         oldest;

  result_t pending_results[$];
  int  errors = 0;
  int  checked = 0;
  int  reads_sent = 0;
  int  stores_sent = 0;
  int  cycles = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  hold_req = 0;
  int  hold_left = 0;
  longint cur_time;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("timestamped_delay_interpolator_unit test failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result tdata=%h tuser=%b", $time, m_axis_tdata,
                 m_axis_tuser);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        checked++;
        for (int c = 0; c < CH; c++) begin
          if (m_axis_tdata[c*16 +: 16] !== exp_r.delayed[c*16 +: 16]) begin
            $display("%0t: delayed_%0d expected %0d actual %0d", $time, c,
                     $signed(exp_r.delayed[c*16 +: 16]), $signed(m_axis_tdata[c*16 +: 16]));
            errors++;
          end
        end
        if (m_axis_tuser !== exp_r.underrun) begin
          $display("%0t: underrun expected %b actual %b", $time, exp_r.underrun,
                   m_axis_tuser);
          errors++;
        end
      end
    end
  end

  function automatic void refill_ring();
    longint t;
    longint step;
    t = -longint'(delay_reg) * (DEPTH - 1) - 1;
    step = longint'(delay_reg) - 1;
    for (int i = 0; i < DEPTH; i++) begin
      if (t > 64'sd2147483647) ring_time[i] = 32'h7fffffff;
      else if (t < -64'sd2147483648) ring_time[i] = 32'h80000000;
      else ring_time[i] = t[31:0];
      for (int c = 0; c < CH; c++) ring_val[c][i] = fill_value;
      t += step;
    end
    oldest = 0;
  endfunction

  function automatic longint round_quotient(longint num, longint den);
    longint q;
    bit neg;
    neg = 1'b0;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    if (num < 0) begin
      neg = 1'b1;
      num = -num;
    end
    q = (2 * num + den) / (2 * den);
    return neg ? -q : q;
  endfunction

  function automatic result_t interpolate(bit op, logic signed [31:0] now, logic [63:0] smp);
    result_t r;
    longint td, ta, tb, span, num, v;
    int lo, hi, mid, a, b, newest, slot;
    r = '0;
    td = longint'(now) - longint'(delay_reg);
    if (op == OP_STORE) begin
      r.underrun = (td < longint'(ring_time[oldest]));
      newest = (oldest + DEPTH - 1) % DEPTH;
      if (longint'(now) > longint'(ring_time[newest])) begin
        slot = oldest;
        oldest = (oldest + 1) % DEPTH;
      end else begin
        slot = newest;
      end
      ring_time[slot] = now;
      for (int c = 0; c < CH; c++) ring_val[c][slot] = smp[c*16 +: 16];
      return r;
    end
    lo = 0;
    hi = DEPTH - 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      ta = ring_time[(mid + oldest) % DEPTH];
      if (td < ta) hi = mid;
      else if (td > ta) lo = mid;
      else begin
        lo = mid;
        hi = mid;
      end
    end
    a = (lo + oldest) % DEPTH;
    b = (hi + oldest) % DEPTH;
    ta = ring_time[a];
    tb = ring_time[b];
    span = tb - ta;
    for (int c = 0; c < CH; c++) begin
      if (span != 0) begin
        num = (tb - td) * longint'(ring_val[c][a]) + (td - ta) * longint'(ring_val[c][b]);
        v = round_quotient(num, span);
      end else begin
        v = ring_val[c][a];
      end
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      r.delayed[c*16 +: 16] = v[15:0];
    end
    return r;
  endfunction

  task automatic send_item(bit op, logic signed [31:0] now, logic [63:0] smp);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = op;
    s_axis_tdata = {smp, now};
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(interpolate(op, now, smp));
    if (op == OP_READ) reads_sent++;
    else stores_sent++;
  endtask

  task automatic store_at(longint now, logic [63:0] smp);
    send_item(OP_STORE, now[31:0], smp);
  endtask

  task automatic read_at(longint now);
    send_item(OP_READ, now[31:0], {$urandom, $urandom});
  endtask

  // wait out every expected result, then let the block settle
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [31:0] value);
    drain();
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = 3'(idx * 4);
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (idx == REG_DELAY) delay_reg = value[DELAY_W-1:0];
    else fill_value = value[15:0];
    refill_ring();
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic test_directed();
    read_at(0);
    store_at(0, {16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff});
    store_at(0, {16'sh8000, 16'sh7fff, 16'shffff, 16'sh0001});
    store_at(10, {16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh0000});
    read_at(110);
    read_at(105);
    read_at(5000);
    read_at(-5000);
    read_at(-2147483648);
    read_at(2147483647);
    store_at(2147483647, 64'hffff_ffff_ffff_ffff);
    store_at(-2147483648, 64'h0000_0000_0000_0000);
    read_at(2147483647);
    store_at(-2147483648, 64'h5555_aaaa_5555_aaaa);
    read_at(0);
  endtask

  task automatic test_config_extremes();
    write_reg(REG_DELAY, 0);
    read_at(-30);
    store_at(-200, 64'h1234_5678_9abc_def0);
    read_at(-50);
    write_reg(REG_DELAY, 1);
    read_at(-70);
    write_reg(REG_INIT, 32'h8000);
    write_reg(REG_DELAY, 32'hfffff);
    read_at(-3);
    store_at(-1048575, 64'h7fff_7fff_7fff_7fff);
    write_reg(REG_INIT, 32'h7fff);
    read_at(0);
    store_at(5, 64'h8000_8000_8000_8000);
    read_at(1048580);
  endtask

  task automatic random_item(int d);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      cur_time += $urandom_range(0, d / 16 + 3);
      store_at(cur_time, {$urandom, $urandom});
    end else if (pick < 88) begin
      read_at(cur_time + d + $urandom_range(0, d / 4 + 3) - $urandom_range(0, 5 * d + 20));
    end else begin
      read_at($signed($urandom));
    end
  endtask

  task automatic test_random_phase(int n, int s_pct, int r_pct, int d);
    write_reg(REG_DELAY, d);
    write_reg(REG_INIT, $urandom_range(0, 65535));
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    cur_time = 0;
    for (int i = 0; i < n; i++) random_item(d);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 500;
    for (int i = 0; i < 30; i++) random_item(100);
    drain();
    for (int i = 0; i < 10; i++) random_item(100);
  endtask

  initial begin
    delay_reg = DELAY_RST;
    fill_value = INIT_RST;
    refill_ring();
    send_idle_pct = 38;
    recv_idle_pct = 48;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_config_extremes();
    test_random_phase(170, 38, 48, $urandom_range(2, 300));
    test_random_phase(170, 48, 38, 64);
    test_random_phase(60, 0, 0, 1048575);
    test_random_phase(110, 0, 0, $urandom_range(1, 40));
    test_backpressure();
    drain();
    $display("ran %0d stores and %0d reads over several delay and fill settings,", stores_sent,
             reads_sent);
    $display("with stalls on both sides; %0d results compared", checked);
    if (errors == 0) begin
      $display("timestamped_delay_interpolator_unit test passed");
    end else begin
      $display("timestamped_delay_interpolator_unit test failed");
    end
    $finish;
  end

endmodule
